@@ design/mcpwc_pkg.sv @@
`default_nettype none

package mcpwc_pkg;

    localparam int FLAG_W  = 8;
    localparam int TIME_W  = 16;
    localparam int CH_W    = 3;
    localparam int PW_W    = 16;
    localparam int MAX_CH  = 8;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMER_TOP = 1'd1;

    localparam logic [FLAG_W-1:0] ENABLE_RST    = 8'hFF;
    localparam logic [TIME_W-1:0] TIMER_TOP_RST = 16'd4001;

    typedef struct packed {
        logic            fall;
        logic [PW_W-1:0] width;
    } t_lane_res;

endpackage

`default_nettype wire

@@ design/mcpwc_lane.sv @@
`default_nettype none

module mcpwc_lane
    import mcpwc_pkg::*;
#(
    parameter int TW = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_hit,
    input  wire logic [TW-1:0] i_now,
    input  wire logic [TW-1:0] i_top,
    output t_lane_res          o_res
);

    logic          r_await;
    logic          n_await;
    logic [TW-1:0] r_rise;
    logic [TW-1:0] n_rise;
    logic [TW-1:0] w_width;

    // a pulse that spans the timer wrap is corrected with the top count
    always_comb begin
        if (r_rise > i_now) begin
            w_width = i_top - r_rise + i_now;
        end else begin
            w_width = i_now - r_rise;
        end
    end

    always_comb begin
        n_await = r_await;
        n_rise  = r_rise;
        if (i_hit) begin
            n_await = ~r_await;
            if (!r_await) begin
                n_rise = i_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_await <= 1'b0;
            r_rise  <= '0;
        end else begin
            r_await <= n_await;
            r_rise  <= n_rise;
        end
    end

    assign o_res.fall  = i_hit & r_await;
    assign o_res.width = PW_W'(w_width);

endmodule

`default_nettype wire

@@ design/mcpwc_merge.sv @@
`default_nettype none

module mcpwc_merge
    import mcpwc_pkg::*;
#(
    parameter int NL = 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_load,
    input  t_lane_res                   i_res [NL],
    output logic                        o_ready,
    output logic                        o_tvalid,
    input  wire logic                   i_tready,
    output logic [OUT_TDATA_W-1:0]      o_tdata,
    output logic                        o_tlast
);

    logic [NL-1:0]   r_pend;
    logic [NL-1:0]   n_pend;
    logic [PW_W-1:0] r_width [NL];
    logic            r_out_valid;
    logic [CH_W-1:0] r_out_ch;
    logic [PW_W-1:0] r_out_width;
    logic            r_out_last;
    logic            w_out_free;
    logic            w_move;
    logic [NL-1:0]   w_pick;
    logic [NL-1:0]   w_fall;
    logic [CH_W-1:0] w_sel_ch;
    logic [PW_W-1:0] w_sel_width;

    assign w_out_free = !r_out_valid || i_tready;
    assign w_move     = w_out_free && (r_pend != '0);
    // lowest pending channel goes first
    assign w_pick     = r_pend & (~r_pend + NL'(1));
    // take a new request only once the current set is leaving
    assign o_ready    = (r_pend == '0) || ($onehot(r_pend) && w_out_free);

    always_comb begin
        w_sel_ch    = '0;
        w_sel_width = '0;
        for (int i = 0; i < NL; i++) begin
            w_fall[i] = i_res[i].fall;
            if (w_pick[i]) begin
                w_sel_ch    = CH_W'(i);
                w_sel_width = r_width[i];
            end
        end
    end

    always_comb begin
        n_pend = r_pend;
        if (w_move) begin
            n_pend = r_pend & ~w_pick;
        end
        if (i_load) begin
            n_pend = w_fall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= n_pend;
            if (w_out_free) begin
                r_out_valid <= w_move;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int i = 0; i < NL; i++) begin
                r_width[i] <= i_res[i].width;
            end
        end
        if (w_move) begin
            r_out_ch    <= w_sel_ch;
            r_out_width <= w_sel_width;
            r_out_last  <= ((r_pend & ~w_pick) == '0);
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tlast  = r_out_last;
    assign o_tdata  = {(OUT_TDATA_W - PW_W - CH_W)'(0), r_out_width, r_out_ch};

    a_load_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (r_pend == '0) || ($onehot(r_pend) && w_move))
        else $error("request loaded over undelivered results");

    a_last_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_move && !i_load) |=> (r_out_last == (r_pend == '0)))
        else $error("last flag disagrees with pending set");

    a_pick_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_move |-> $onehot(w_pick))
        else $error("merge picked other than one channel");

endmodule

`default_nettype wire

@@ design/multi_channel_pulse_width_capture_top.sv @@
// Pulse-width capture for up to eight RC receiver pins.
// Input stream: each request carries the pin edge flags and the timer count
// captured at the event. Channels with their enable bit set alternate between
// storing a rise time and reporting a high-time width on the next edge.
// Output stream: one result per falling edge, in ascending channel order,
// with tlast on the final result of a request.
// Config channel: index 0 writes channel_enable, index 1 writes timer_top;
// always ready, write only while the stream is idle.
// An accepted request's results wait in the pending register, then move one
// by one to the output register; the next request is taken in the cycle the
// last result of the previous one moves to the output register, so requests
// with at most one result flow at one per cycle while the receiver does not
// stall. The one-result-per-cycle merge stage sets this rate.
// Reset: all channels await a rising edge, stored rise times are zero,
// channel_enable is 0xFF and timer_top is 4001.
// A stalled receiver holds the output register, the merge stage fills behind
// it, and s_axis_tready drops until the pending results drain.
`default_nettype none

module multi_channel_pulse_width_capture_top
    import mcpwc_pkg::*;
#(
    parameter int NUM_CHANNELS = 8,
    parameter int TIMER_BITS   = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // [7:0] edge_flags, [23:8] timer_value
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [2:0] channel, [18:3] pulse_width, [23:19] zero
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                        m_axis_tlast,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int NL = (NUM_CHANNELS < MAX_CH) ? NUM_CHANNELS : MAX_CH;

    logic [FLAG_W-1:0]     r_enable;
    logic [TIME_W-1:0]     r_top;
    logic                  w_accept;
    logic [FLAG_W-1:0]     w_flags;
    logic [TIMER_BITS-1:0] w_now;
    logic [TIMER_BITS-1:0] w_top;
    t_lane_res             w_res [NL];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= ENABLE_RST;
            r_top    <= TIMER_TOP_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ENABLE:    r_enable <= i_cfg_data[FLAG_W-1:0];
                CFG_TIMER_TOP: r_top    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_flags  = s_axis_tdata[FLAG_W-1:0] & r_enable;
    assign w_now    = TIMER_BITS'(s_axis_tdata[FLAG_W +: TIME_W]);
    assign w_top    = TIMER_BITS'(r_top);

    for (genvar g = 0; g < NL; g++) begin : g_lane
        mcpwc_lane #(
            .TW(TIMER_BITS)
        ) u_lane (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_hit  (w_accept && w_flags[g]),
            .i_now  (w_now),
            .i_top  (w_top),
            .o_res  (w_res[g])
        );
    end

    mcpwc_merge #(
        .NL(NL)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_accept),
        .i_res   (w_res),
        .o_ready (s_axis_tready),
        .o_tvalid(m_axis_tvalid),
        .i_tready(m_axis_tready),
        .o_tdata (m_axis_tdata),
        .o_tlast (m_axis_tlast)
    );

endmodule

`default_nettype wire

@@ tb/tb_multi_channel_pulse_width_capture_top.sv @@
`default_nettype none

module tb_multi_channel_pulse_width_capture_top;
    import mcpwc_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASES        = 6;
    localparam int PHASE_EVENTS  = 31;

    typedef struct packed {
        logic [CH_W-1:0] channel;
        logic [PW_W-1:0] width;
        logic            last;
    } t_pulse;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    // predictor state
    logic [FLAG_W-1:0] enable_mask   = ENABLE_RST;
    logic [TIME_W-1:0] top_count     = TIMER_TOP_RST;
    logic [MAX_CH-1:0] awaiting_fall = '0;
    logic [TIME_W-1:0] rise_stamp [MAX_CH];
    t_pulse            pending_pulses [$];

    // stimulus control
    int          burst_left = 0;
    int          gap_max = 0;
    logic [15:0] tick = '0;
    logic [7:0]  sink_pattern = 8'hFF;
    int          hold_ticket = 0;

    // receiver-owned state
    int          hold_served = 0;
    int          hold_left = 0;
    logic [2:0]  sink_pos = '0;

    int events_sent = 0;
    int widths_checked = 0;
    int reg_writes = 0;
    int mismatches = 0;
    int cycle_count = 0;

    always #4 i_clk = ~i_clk;

    multi_channel_pulse_width_capture_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Advance channel phases for one request and queue the widths it ends.
    task automatic capture_edges(input logic [FLAG_W-1:0] flags, input logic [TIME_W-1:0] now);
        logic [FLAG_W-1:0] live;
        logic [PW_W-1:0]   w;
        t_pulse            p;
        t_pulse            batch [$];
        live = flags & enable_mask;
        for (int ch = 0; ch < MAX_CH; ch++) begin
            if (live[ch]) begin
                if (!awaiting_fall[ch]) begin
                    rise_stamp[ch]    = now;
                    awaiting_fall[ch] = 1'b1;
                end else begin
                    if (rise_stamp[ch] > now)
                        w = top_count - rise_stamp[ch] + now;
                    else
                        w = now - rise_stamp[ch];
                    awaiting_fall[ch] = 1'b0;
                    p.channel = 3'(ch);
                    p.width   = w;
                    p.last    = 1'b0;
                    batch.push_back(p);
                end
            end
        end
        if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i])
            pending_pulses.push_back(batch[i]);
    endtask

    task automatic send_event(input logic [FLAG_W-1:0] flags, input logic [TIME_W-1:0] now);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if (gap_max > 0) begin
                gap = $urandom_range(1, gap_max);
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {now, flags};
        do @(posedge i_clk); while (!s_axis_tready);
        capture_edges(flags, now);
        burst_left--;
        events_sent++;
    endtask

    task automatic end_stream();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
    endtask

    // Hold until every queued width is out, then let requests without results settle.
    task automatic wait_idle();
        while (pending_pulses.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        end_stream();
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_ENABLE)
            enable_mask = data[FLAG_W-1:0];
        else
            top_count = data;
        reg_writes++;
    endtask

    task automatic test_reset_defaults();
        gap_max = 0;
        sink_pattern <= 8'hFF;
        send_event(8'h00, 16'd500);
        send_event(8'hFF, 16'd100);
        send_event(8'hFF, 16'd1600);
        send_event(8'h01, 16'd3900);
        send_event(8'h80, 16'd0);
        // ch0 wraps against the reset top count, ch7 does not
        send_event(8'h81, 16'd50);
        send_event(8'hFF, 16'hFFFF);
        send_event(8'hFF, 16'hFFFF);
    endtask

    task automatic test_disabled_channels();
        write_reg(CFG_ENABLE, 16'h5A0F);
        send_event(8'hFF, 16'd1000);
        send_event(8'hF0, 16'd1200);
        write_reg(CFG_ENABLE, 16'h0000);
        send_event(8'hFF, 16'd1300);
        // disabled pins resume from the phase they were left in
        write_reg(CFG_ENABLE, 16'hA5FF);
        send_event(8'hFF, 16'd2000);
        send_event(8'hF0, 16'd2600);
    endtask

    task automatic test_timer_wrap();
        write_reg(CFG_TIMER_TOP, 16'h0000);
        send_event(8'h01, 16'hFFFF);
        send_event(8'h01, 16'h0000);
        write_reg(CFG_TIMER_TOP, 16'hFFFF);
        send_event(8'h02, 16'hFFFF);
        send_event(8'h02, 16'h0000);
        send_event(8'h04, 16'h0000);
        send_event(8'h04, 16'hFFFF);
        send_event(8'h08, 16'h5555);
        send_event(8'h08, 16'h5555);
    endtask

    task automatic test_backpressure();
        gap_max = 0;
        sink_pattern <= 8'hFF;
        hold_ticket <= hold_ticket + 1;
        // every second request ends eight pulses, and the receiver is held as the burst starts
        for (int i = 0; i < 24; i++)
            send_event(8'hFF, 16'($urandom));
    endtask

    task automatic test_random_traffic();
        logic [FLAG_W-1:0] flags;
        logic [TIME_W-1:0] now;
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_ENABLE, 16'h00FF);
                    write_reg(CFG_TIMER_TOP, 16'hFFFF);
                end
                1: begin
                    write_reg(CFG_ENABLE, 16'($urandom));
                    write_reg(CFG_TIMER_TOP, 16'h0000);
                end
                3: begin
                    write_reg(CFG_ENABLE, 16'($urandom) | 16'h0081);
                    write_reg(CFG_TIMER_TOP, TIMER_TOP_RST);
                end
                default: begin
                    write_reg(CFG_ENABLE, 16'($urandom));
                    write_reg(CFG_TIMER_TOP, 16'($urandom));
                end
            endcase
            gap_max = (ph % 3 == 0) ? 0 : $urandom_range(2, 10);
            if (ph % 2 == 0)
                sink_pattern <= 8'hFF;
            else
                sink_pattern <= 8'($urandom) | 8'(1 << $urandom_range(0, 7));
            for (int i = 0; i < PHASE_EVENTS; i++) begin
                case ($urandom_range(0, 9))
                    0:       flags = '0;
                    1:       flags = 8'(1 << $urandom_range(0, 7));
                    default: flags = 8'($urandom);
                endcase
                if ($urandom_range(0, 3) == 0) begin
                    now = 16'($urandom);
                end else begin
                    tick = tick + 16'($urandom_range(0, 3000));
                    now  = tick;
                end
                send_event(flags, now);
            end
        end
        end_stream();
    endtask

    always @(posedge i_clk) begin : drive_ready
        if (hold_ticket != hold_served) begin
            hold_served = hold_ticket;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= sink_pattern[sink_pos];
            sink_pos = sink_pos + 3'd1;
        end
    end

    always @(posedge i_clk) begin : check_width
        t_pulse want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            widths_checked++;
            if (pending_pulses.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result channel=%0d width=%0d last=%0b", $time,
                         m_axis_tdata[CH_W-1:0], m_axis_tdata[CH_W+PW_W-1:CH_W], m_axis_tlast);
            end else begin
                want = pending_pulses.pop_front();
                if (m_axis_tdata[CH_W-1:0] !== want.channel) begin
                    mismatches++;
                    $display("%0t: channel expected %0d got %0d", $time,
                             want.channel, m_axis_tdata[CH_W-1:0]);
                end
                if (m_axis_tdata[CH_W+PW_W-1:CH_W] !== want.width) begin
                    mismatches++;
                    $display("%0t: width on channel %0d expected %0d got %0d", $time,
                             want.channel, want.width, m_axis_tdata[CH_W+PW_W-1:CH_W]);
                end
                if (m_axis_tlast !== want.last) begin
                    mismatches++;
                    $display("%0t: tlast on channel %0d expected %0b got %0b", $time,
                             want.channel, want.last, m_axis_tlast);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d widths outstanding", $time, pending_pulses.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        foreach (rise_stamp[i])
            rise_stamp[i] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_disabled_channels();
        test_timer_wrap();
        test_backpressure();
        test_random_traffic();
        wait_idle();
        repeat (2 * SETTLE_CYCLES) @(posedge i_clk);
        $display("Covered %0d edge requests, %0d pulse widths, %0d register writes;",
                 events_sent, widths_checked, reg_writes);
        $display("timer wraps, masked pins and a %0d-cycle receiver hold included.",
                 HOLD_CYCLES);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
